FILE: rtl/fsp_pkg.sv
`timescale 1ns / 1ps

package fsp_pkg;

   localparam int MEM_WORDS_DEFAULT = 1024;
   localparam int REG_COUNT_DEFAULT = 8;

   localparam logic [31:0] NOOP_WORD = 32'h01c0_0000;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_NOR  = 3'd1;
   localparam logic [2:0] OP_LW   = 3'd2;
   localparam logic [2:0] OP_SW   = 3'd3;
   localparam logic [2:0] OP_BEQ  = 3'd4;
   localparam logic [2:0] OP_JALR = 3'd5;
   localparam logic [2:0] OP_HALT = 3'd6;
   localparam logic [2:0] OP_NOOP = 3'd7;

   localparam logic OPER_PRELOAD = 1'b0;
   localparam logic OPER_TICK    = 1'b1;

   typedef struct packed {
      logic stall;
      logic flush;
   } fsp_ctrl_type;

   function automatic logic [2:0] op_of(input logic [31:0] w);
      return w[24:22];
   endfunction

   function automatic logic [2:0] ra_of(input logic [31:0] w);
      return w[21:19];
   endfunction

   function automatic logic [2:0] rb_of(input logic [31:0] w);
      return w[18:16];
   endfunction

   // Whether the instruction writes a register when it retires.
   function automatic logic writes_reg(input logic [31:0] w);
      return (op_of(w) == OP_ADD) || (op_of(w) == OP_NOR) || (op_of(w) == OP_LW);
   endfunction

   function automatic logic [2:0] wreg_of(input logic [31:0] w);
      return (op_of(w) == OP_LW) ? w[18:16] : w[2:0];
   endfunction

endpackage

FILE: rtl/fsp_hazard.sv
`timescale 1ns / 1ps

module fsp_hazard (
   input  logic [31:0]           fd_instr,
   input  logic [31:0]           dx_instr,
   input  logic [31:0]           xm_instr,
   input  logic                  xm_equal,
   input  logic [31:0]           mw_instr,
   input  logic [31:0]           we_instr,
   input  logic [31:0]           dx_operand_a,
   input  logic [31:0]           dx_operand_b,
   input  logic [31:0]           xm_alu_value,
   input  logic [31:0]           mw_value,
   input  logic [31:0]           we_value,
   output logic [31:0]           fwd_a,
   output logic [31:0]           fwd_b,
   output fsp_pkg::fsp_ctrl_type ctrl
);
   import fsp_pkg::*;

   logic [2:0] fop;
   logic [2:0] xop;
   logic [2:0] target;

   // Load-use detection and the taken-branch flush.
   always_comb begin
      fop = op_of(fd_instr);
      xop = op_of(xm_instr);
      target = rb_of(dx_instr);
      ctrl.stall = 1'b0;
      if (op_of(dx_instr) == OP_LW) begin
         case (fop)
            OP_ADD, OP_NOR, OP_SW, OP_BEQ: begin
               ctrl.stall = (target == ra_of(fd_instr)) || (target == rb_of(fd_instr));
            end
            OP_LW: begin
               ctrl.stall = (target == ra_of(fd_instr));
            end
            default: begin
               ctrl.stall = 1'b0;
            end
         endcase
      end
      ctrl.flush = (xop == OP_BEQ) && xm_equal;
   end

   // Oldest producer first so that the youngest one wins.
   always_comb begin
      fwd_a = dx_operand_a;
      fwd_b = dx_operand_b;
      if (writes_reg(we_instr)) begin
         if (wreg_of(we_instr) == ra_of(dx_instr)) fwd_a = we_value;
         if (wreg_of(we_instr) == rb_of(dx_instr)) fwd_b = we_value;
      end
      if (writes_reg(mw_instr)) begin
         if (wreg_of(mw_instr) == ra_of(dx_instr)) fwd_a = mw_value;
         if (wreg_of(mw_instr) == rb_of(dx_instr)) fwd_b = mw_value;
      end
      if (op_of(xm_instr) == OP_ADD || op_of(xm_instr) == OP_NOR) begin
         if (xm_instr[2:0] == ra_of(dx_instr)) fwd_a = xm_alu_value;
         if (xm_instr[2:0] == rb_of(dx_instr)) fwd_b = xm_alu_value;
      end
   end

endmodule

FILE: rtl/five_stage_pipelined_cpu_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid/req_ready  | operation, load_address, load_word
// rsp     | out       | rsp_valid/rsp_ready  | pipeline state and events of one item
// Each accepted word is answered from the result register; one word per cycle is sustained
// while rsp_ready is high. The instruction, data and register memories are read through
// registers and addressed with the next program counter, load address and decode operands.
// Reset clears the pipeline registers and the register-file valid bits; the stores
// are undefined until preloaded. req_ready is low only while a result waits and
// rsp_ready is low.
module five_stage_pipelined_cpu_top #(
   parameter int MEM_WORDS = fsp_pkg::MEM_WORDS_DEFAULT,
   parameter int REG_COUNT = fsp_pkg::REG_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [9:0]  req_load_address,
   input  logic [31:0] req_load_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_fetch_address,
   output logic [31:0] rsp_cycles_run,
   output logic        rsp_stopped,
   output logic        rsp_write_back_valid,
   output logic [2:0]  rsp_write_back_index,
   output logic [31:0] rsp_write_back_value,
   output logic        rsp_store_valid,
   output logic [9:0]  rsp_store_address,
   output logic [31:0] rsp_store_value,
   output logic        rsp_stall_taken,
   output logic        rsp_flush_taken
);
   import fsp_pkg::*;

   // Addresses wrap by masking, so the store depth must be a power of two; the module does not check it.
   localparam int AW = $clog2(MEM_WORDS);
   localparam int RW = $clog2(REG_COUNT);

   // Memories.
   logic [31:0] imem [MEM_WORDS];
   logic [31:0] dmem [MEM_WORDS];
   logic [31:0] rf [REG_COUNT];
   logic [REG_COUNT-1:0] rf_valid_ff;

   logic [31:0] imem_rd_ff, dmem_rd_ff, rf_a_ff, rf_b_ff;
   logic        rf_a_valid_ff, rf_b_valid_ff;

   // Pipeline registers.
   logic [AW-1:0] pc_ff, pc_in;
   logic [31:0]   fd_i_ff, fd_i_in;
   logic [AW-1:0] fd_n_ff, fd_n_in;
   logic [31:0]   dx_i_ff, dx_i_in;
   logic [AW-1:0] dx_n_ff;
   logic [31:0]   dx_a_ff, dx_b_ff;
   logic [15:0]   dx_imm_ff;
   logic [31:0]   xm_i_ff, xm_i_in;
   logic [AW-1:0] xm_t_ff;
   logic          xm_e_ff;
   logic [31:0]   xm_alu_ff, xm_alu_in;
   logic [31:0]   xm_sd_ff;
   logic [31:0]   mw_i_ff, mw_v_ff, mw_v_in;
   logic [31:0]   we_i_ff, we_v_ff;
   logic [31:0]   cycle_ff;
   logic          halt_ff;

   logic [9:0]  out_pc_ff;
   logic [31:0] out_cyc_ff, out_wbv_ff, out_stv_ff;
   logic        out_stop_ff, out_wb_ff, out_st_ff, out_stall_ff, out_flush_ff;
   logic [2:0]  out_wbi_ff;
   logic [9:0]  out_sta_ff;
   logic        rsp_valid_ff;

   logic          fire, step, preload;
   logic [31:0]   fwd_a, fwd_b, imm32, dx_a_src, dx_b_src;
   fsp_ctrl_type  ctrl;
   logic          stall_eff;
   logic [AW-1:0] pc_plus;
   logic          st_en, wb_en;
   logic [AW-1:0] st_addr, imem_ra, dmem_ra, dmem_wa;
   logic [31:0]   dmem_wd;
   logic          dmem_we;
   logic [RW-1:0] rf_ra, rf_rb, rf_wa;
   logic [2:0]    wb_idx;
   logic          rf_a_hit, rf_b_hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign preload   = fire && (req_operation == OPER_PRELOAD);
   assign step      = fire && (req_operation == OPER_TICK) && !halt_ff;

   fsp_hazard u_hazard (
      .fd_instr     (fd_i_ff),
      .dx_instr     (dx_i_ff),
      .xm_instr     (xm_i_ff),
      .xm_equal     (xm_e_ff),
      .mw_instr     (mw_i_ff),
      .we_instr     (we_i_ff),
      .dx_operand_a (dx_a_ff),
      .dx_operand_b (dx_b_ff),
      .xm_alu_value (xm_alu_ff),
      .mw_value     (mw_v_ff),
      .we_value     (we_v_ff),
      .fwd_a        (fwd_a),
      .fwd_b        (fwd_b),
      .ctrl         (ctrl)
   );

   always_comb begin
      imm32     = {{16{dx_imm_ff[15]}}, dx_imm_ff};
      stall_eff = ctrl.stall && !ctrl.flush;
      pc_plus   = pc_ff + AW'(1);

      if (ctrl.flush) pc_in = xm_t_ff;
      else if (ctrl.stall) pc_in = pc_ff;
      else pc_in = pc_plus;

      // The next address keeps the stall choice even when a flush wins.
      fd_n_in = ctrl.stall ? fd_n_ff : pc_plus;
      if (ctrl.flush) fd_i_in = NOOP_WORD;
      else if (ctrl.stall) fd_i_in = fd_i_ff;
      else fd_i_in = imem_rd_ff;
      dx_i_in = (ctrl.stall || ctrl.flush) ? NOOP_WORD : fd_i_ff;
      xm_i_in = ctrl.flush ? NOOP_WORD : dx_i_ff;

      case (op_of(dx_i_ff))
         OP_LW, OP_SW: xm_alu_in = fwd_a + imm32;
         OP_ADD:       xm_alu_in = fwd_a + fwd_b;
         OP_NOR:       xm_alu_in = ~(fwd_a | fwd_b);
         default:      xm_alu_in = 32'd0;
      endcase

      st_en   = op_of(xm_i_ff) == OP_SW;
      st_addr = xm_alu_ff[AW-1:0];
      mw_v_in = (op_of(xm_i_ff) == OP_LW) ? dmem_rd_ff : xm_alu_ff;
      wb_en   = writes_reg(mw_i_ff);
      wb_idx  = wreg_of(mw_i_ff);
      rf_wa   = RW'(wb_idx);

      dx_a_src = rf_a_valid_ff ? rf_a_ff : 32'd0;
      dx_b_src = rf_b_valid_ff ? rf_b_ff : 32'd0;

      // Read addresses come from the next state on a step, ahead of the state that uses them.
      imem_ra = step ? pc_in : pc_ff;
      dmem_ra = step ? xm_alu_in[AW-1:0] : xm_alu_ff[AW-1:0];
      rf_ra   = step ? RW'(ra_of(fd_i_in)) : RW'(ra_of(fd_i_ff));
      rf_rb   = step ? RW'(rb_of(fd_i_in)) : RW'(rb_of(fd_i_ff));

      rf_a_hit = step && wb_en && (rf_wa == rf_ra);
      rf_b_hit = step && wb_en && (rf_wa == rf_rb);

      dmem_we = preload || (step && st_en);
      dmem_wa = preload ? AW'(req_load_address) : st_addr;
      dmem_wd = preload ? req_load_word : xm_sd_ff;
   end

   always_ff @(posedge clock) begin
      if (preload) imem[AW'(req_load_address)] <= req_load_word;
      if (preload && AW'(req_load_address) == imem_ra) imem_rd_ff <= req_load_word;
      else imem_rd_ff <= imem[imem_ra];
   end

   always_ff @(posedge clock) begin
      if (dmem_we) dmem[dmem_wa] <= dmem_wd;
      if (dmem_we && dmem_wa == dmem_ra) dmem_rd_ff <= dmem_wd;
      else dmem_rd_ff <= dmem[dmem_ra];
   end

   always_ff @(posedge clock) begin
      if (step && wb_en) rf[rf_wa] <= mw_v_ff;
      if (rf_a_hit) rf_a_ff <= mw_v_ff;
      else rf_a_ff <= rf[rf_ra];
      if (rf_b_hit) rf_b_ff <= mw_v_ff;
      else rf_b_ff <= rf[rf_rb];
      if (reset) begin
         rf_valid_ff <= '0;
         rf_a_valid_ff <= 1'b0;
         rf_b_valid_ff <= 1'b0;
      end else begin
         rf_a_valid_ff <= rf_a_hit || rf_valid_ff[rf_ra];
         rf_b_valid_ff <= rf_b_hit || rf_valid_ff[rf_rb];
         if (step && wb_en) rf_valid_ff[rf_wa] <= 1'b1;
      end
   end

   // Pipeline state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         fd_i_ff <= NOOP_WORD;
         fd_n_ff <= '0;
         dx_i_ff <= NOOP_WORD;
         dx_n_ff <= '0;
         dx_a_ff <= '0;
         dx_b_ff <= '0;
         dx_imm_ff <= '0;
         xm_i_ff <= NOOP_WORD;
         xm_t_ff <= '0;
         xm_e_ff <= 1'b0;
         xm_alu_ff <= '0;
         xm_sd_ff <= '0;
         mw_i_ff <= NOOP_WORD;
         mw_v_ff <= '0;
         we_i_ff <= NOOP_WORD;
         we_v_ff <= '0;
         cycle_ff <= '0;
         halt_ff <= 1'b0;
      end else if (step) begin
         pc_ff <= pc_in;
         fd_i_ff <= fd_i_in;
         fd_n_ff <= fd_n_in;
         dx_i_ff <= dx_i_in;
         dx_n_ff <= fd_n_ff;
         dx_a_ff <= dx_a_src;
         dx_b_ff <= dx_b_src;
         dx_imm_ff <= fd_i_ff[15:0];
         xm_i_ff <= xm_i_in;
         xm_t_ff <= dx_n_ff + imm32[AW-1:0];
         xm_e_ff <= (fwd_a == fwd_b);
         xm_alu_ff <= xm_alu_in;
         xm_sd_ff <= fwd_b;
         mw_i_ff <= xm_i_ff;
         mw_v_ff <= mw_v_in;
         we_i_ff <= mw_i_ff;
         we_v_ff <= mw_v_ff;
         if (cycle_ff != 32'hFFFF_FFFF) cycle_ff <= cycle_ff + 32'd1;
         if (op_of(xm_i_ff) == OP_HALT) halt_ff <= 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         out_pc_ff    <= step ? 10'(pc_in) : 10'(pc_ff);
         out_cyc_ff   <= (step && cycle_ff != 32'hFFFF_FFFF) ? cycle_ff + 32'd1 : cycle_ff;
         out_stop_ff  <= halt_ff || (step && op_of(xm_i_ff) == OP_HALT);
         out_wb_ff    <= step && wb_en;
         out_wbi_ff   <= (step && wb_en) ? wb_idx : 3'd0;
         out_wbv_ff   <= (step && wb_en) ? mw_v_ff : 32'd0;
         out_st_ff    <= step && st_en;
         out_sta_ff   <= (step && st_en) ? 10'(st_addr) : 10'd0;
         out_stv_ff   <= (step && st_en) ? xm_sd_ff : 32'd0;
         out_stall_ff <= step && stall_eff;
         out_flush_ff <= step && ctrl.flush;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_fetch_address    = out_pc_ff;
   assign rsp_cycles_run       = out_cyc_ff;
   assign rsp_stopped          = out_stop_ff;
   assign rsp_write_back_valid = out_wb_ff;
   assign rsp_write_back_index = out_wbi_ff;
   assign rsp_write_back_value = out_wbv_ff;
   assign rsp_store_valid      = out_st_ff;
   assign rsp_store_address    = out_sta_ff;
   assign rsp_store_value      = out_stv_ff;
   assign rsp_stall_taken      = out_stall_ff;
   assign rsp_flush_taken      = out_flush_ff;

`ifndef SYNTHESIS
   a_stall_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(out_stall_ff && out_flush_ff))
      else $error("stall and flush reported together");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt cleared without reset");
   a_cycle_moves: assert property (@(posedge clock) disable iff (reset)
      step |=> cycle_ff != 32'd0)
      else $error("cycle count did not advance");
   a_no_step_halt: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> !step)
      else $error("pipeline advanced after halt");
`endif

endmodule
